[sv/ctc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ctc_pkg;

    localparam int          SLOTS_DEFAULT = 16;
    localparam int          QUEUE_DEPTH   = 2;
    localparam logic [15:0] TAG_VALUE     = 16'hA6C5;
    localparam logic [31:0] SEED_MIX      = 32'hA6C50001;
    localparam logic [31:0] GOLDEN        = 32'h9E3779B9;
    localparam logic [4:0]  COUNT_MAX     = 5'd31;

    localparam logic [6:0] R_READ    = 7'h01;
    localparam logic [6:0] R_WAIT    = 7'h04;
    localparam logic [6:0] R_PRESENT = 7'h08;
    localparam logic [6:0] R_SEND    = 7'h10;
    localparam logic [6:0] R_RECEIVE = 7'h20;
    localparam logic [6:0] R_CONNECT = 7'h40;

    localparam logic [7:0] TY_CLOCK   = 8'd1;
    localparam logic [7:0] TY_INPUT   = 8'd2;
    localparam logic [7:0] TY_SURFACE = 8'd3;
    localparam logic [7:0] TY_IPC     = 8'd4;
    localparam logic [7:0] TY_STREAM  = 8'd5;
    localparam logic [7:0] TY_RAWNET  = 8'd6;

    typedef enum logic [2:0] {
        OP_INIT    = 3'd0,
        OP_GRANT   = 3'd1,
        OP_RESOLVE = 3'd2,
        OP_FIND    = 3'd3,
        OP_REVOKE  = 3'd4,
        OP_COUNT   = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_SCAN,
        ST_READ,
        ST_CHECK,
        ST_RESP
    } state_t;

    // classified command handed from front to back
    typedef struct packed {
        op_t         op;
        logic        bad;       // unused command code
        logic        p_zero;    // principal is zero
        logic        grant_ok;  // requested rights legal for type
        logic        slot_ok;   // handle tag and slot decode
        logic [7:0]  slot;
        logic [7:0]  cap_type;
        logic [15:0] rights;
        logic [63:0] obj;
        logic [63:0] handle;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  typ;
        logic [6:0]  rgt;
        logic [63:0] obj;
        logic [31:0] gen;
    } entry_t;

    function automatic logic [6:0] rights_for_type(input logic [7:0] t);
        logic [6:0] r;
        case (t)
            TY_CLOCK:   r = R_READ;
            TY_INPUT:   r = R_READ | R_WAIT;
            TY_SURFACE: r = R_PRESENT;
            TY_IPC:     r = R_SEND | R_RECEIVE;
            TY_STREAM:  r = R_CONNECT;
            TY_RAWNET:  r = R_CONNECT;
            default:    r = 7'd0;
        endcase
        return r;
    endfunction

    // n is slot number plus one
    function automatic logic [31:0] seed_gen(input logic [63:0] p, input logic [7:0] n);
        logic [31:0] prod;
        logic [31:0] g;
        prod = 32'(32'(n) * GOLDEN);
        g    = p[31:0] ^ p[63:32] ^ SEED_MIX ^ prod;
        return (g != 32'd0) ? g : {24'd0, n};
    endfunction

endpackage
`default_nettype wire

[sv/ctc_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module ctc_front #(
    parameter int SLOTS = ctc_pkg::SLOTS_DEFAULT
) (
    input  wire logic           s_tvalid,
    output      logic           s_tready,
    input  wire logic [151:0]   s_tdata,
    input  wire logic [2:0]     s_tuser,
    input  wire logic           p_zero,
    output      logic           push,
    output      ctc_pkg::cmd_t  push_cmd,
    input  wire logic           q_full
);

    logic [7:0]  cap_type;
    logic [15:0] rights;
    logic [63:0] handle;
    logic [6:0]  legal;
    logic [7:0]  e;

    assign cap_type = s_tdata[7:0];
    assign rights   = s_tdata[23:8];
    assign handle   = s_tdata[151:88];
    assign legal    = ctc_pkg::rights_for_type(cap_type);
    assign e        = handle[7:0];

    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready;

    always_comb begin
        push_cmd.bad      = (s_tuser > 3'(ctc_pkg::OP_COUNT));
        push_cmd.op       = push_cmd.bad ? ctc_pkg::OP_INIT : ctc_pkg::op_t'(s_tuser);
        push_cmd.p_zero   = p_zero;
        push_cmd.grant_ok = (legal != 7'd0) && (rights != 16'd0)
                            && ((rights & ~{9'd0, legal}) == 16'd0);
        push_cmd.slot_ok  = (handle[63:48] == ctc_pkg::TAG_VALUE) && (e != 8'd0)
                            && ({1'b0, e} <= 9'(SLOTS));
        push_cmd.slot     = e - 8'd1;
        push_cmd.cap_type = cap_type;
        push_cmd.rights   = rights;
        push_cmd.obj      = s_tdata[87:24];
        push_cmd.handle   = handle;
    end

endmodule
`default_nettype wire

[sv/ctc_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module ctc_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire ctc_pkg::cmd_t  push_cmd,
    output      logic           full,
    input  wire logic           pop,
    output      logic           q_valid,
    output      ctc_pkg::cmd_t  q_cmd
);

    localparam int D  = ctc_pkg::QUEUE_DEPTH;
    localparam int PW = (D > 1) ? $clog2(D) : 1;
    localparam int CW = $clog2(D + 1);

    ctc_pkg::cmd_t   buf_reg [D];
    logic [PW-1:0]   wp_reg, wp_next, rp_reg, rp_next;
    logic [CW-1:0]   cnt_reg, cnt_next;

    assign full    = (cnt_reg == CW'(D));
    assign q_valid = (cnt_reg != '0);
    assign q_cmd   = buf_reg[rp_reg];

    always_comb begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wp_next = (wp_reg == PW'(D - 1)) ? '0 : wp_reg + 1'b1;
        end
        if (pop) begin
            rp_next = (rp_reg == PW'(D - 1)) ? '0 : rp_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wp_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

[sv/ctc_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module ctc_back #(
    parameter int SLOTS = ctc_pkg::SLOTS_DEFAULT
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic [63:0]    principal,
    input  wire logic           q_valid,
    input  wire ctc_pkg::cmd_t  q_cmd,
    output      logic           pop,
    output      logic           m_tvalid,
    input  wire logic           m_tready,
    output      logic [135:0]   m_tdata,
    output      logic           m_tuser
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int IW = $clog2(SLOTS + 1);

    ctc_pkg::state_t state_reg, state_next;
    ctc_pkg::cmd_t   cur_reg, cur_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic            chk_reg, chk_next;

    logic            res_ok_reg, res_ok_next;
    logic [63:0]     res_handle_reg, res_handle_next;
    logic [63:0]     res_obj_reg, res_obj_next;
    logic [4:0]      res_cnt_reg, res_cnt_next;

    logic            out_valid_reg, out_valid_next;
    logic            out_ok_reg;
    logic [63:0]     out_handle_reg, out_obj_reg;
    logic [4:0]      out_cnt_reg;
    logic            out_load;

    // table storage; vld marks entries written since reset
    ctc_pkg::entry_t mem [SLOTS];
    logic [SLOTS-1:0] vld_reg;
    logic            wr_en;
    logic [SW-1:0]   wr_addr, rd_addr;
    ctc_pkg::entry_t wr_data, rd_data_reg, eff;
    logic [SW-1:0]   rd_slot_reg;
    logic            rd_vld_reg;
    logic [7:0]      rd_n;
    logic [7:0]      ty;
    logic [15:0]     rg;
    logic            type_hit, rights_hit, scan_end;
    logic [31:0]     gen_inc;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
        rd_vld_reg  <= vld_reg[rd_addr];
        rd_slot_reg <= rd_addr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr_en) begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_n = 8'(rd_slot_reg) + 8'd1;

    always_comb begin
        if (rd_vld_reg) begin
            eff = rd_data_reg;
        end else begin
            eff.typ = 3'd0;
            eff.rgt = 7'd0;
            eff.obj = 64'd0;
            eff.gen = ctc_pkg::seed_gen(64'd0, rd_n);
        end
    end

    assign ty         = cur_reg.cap_type;
    assign rg         = cur_reg.rights;
    assign type_hit   = ({5'd0, eff.typ} == ty);
    assign rights_hit = (({9'd0, eff.rgt} & rg) == rg);
    assign scan_end   = !chk_reg && (idx_reg == IW'(SLOTS));
    assign gen_inc    = (eff.gen == 32'hFFFFFFFF) ? 32'd1 : eff.gen + 32'd1;
    assign out_load   = (state_reg == ctc_pkg::ST_RESP) && (!out_valid_reg || m_tready);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ctc_pkg::ST_IDLE: begin
                if (q_valid) begin
                    state_next = ctc_pkg::ST_RESP;
                    if (!q_cmd.bad) begin
                        case (q_cmd.op)
                            ctc_pkg::OP_INIT:    state_next = ctc_pkg::ST_SWEEP;
                            ctc_pkg::OP_GRANT:   if (!q_cmd.p_zero && q_cmd.grant_ok)
                                                     state_next = ctc_pkg::ST_SCAN;
                            ctc_pkg::OP_FIND:    if (!q_cmd.p_zero)
                                                     state_next = ctc_pkg::ST_SCAN;
                            ctc_pkg::OP_COUNT:   state_next = ctc_pkg::ST_SCAN;
                            ctc_pkg::OP_RESOLVE: if (!q_cmd.p_zero && q_cmd.slot_ok)
                                                     state_next = ctc_pkg::ST_READ;
                            ctc_pkg::OP_REVOKE:  if (q_cmd.slot_ok)
                                                     state_next = ctc_pkg::ST_READ;
                            default:             state_next = ctc_pkg::ST_RESP;
                        endcase
                    end
                end
            end
            ctc_pkg::ST_SWEEP: begin
                if (idx_reg == IW'(SLOTS - 1)) state_next = ctc_pkg::ST_RESP;
            end
            ctc_pkg::ST_SCAN: begin
                if (scan_end) begin
                    state_next = ctc_pkg::ST_RESP;
                end else if (chk_reg) begin
                    if (cur_reg.op == ctc_pkg::OP_GRANT && eff.typ == 3'd0)
                        state_next = ctc_pkg::ST_RESP;
                    if (cur_reg.op == ctc_pkg::OP_FIND && type_hit && rights_hit)
                        state_next = ctc_pkg::ST_RESP;
                end
            end
            ctc_pkg::ST_READ:  state_next = ctc_pkg::ST_CHECK;
            ctc_pkg::ST_CHECK: state_next = ctc_pkg::ST_RESP;
            ctc_pkg::ST_RESP: begin
                if (out_load) state_next = ctc_pkg::ST_IDLE;
            end
            default: state_next = ctc_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        pop             = 1'b0;
        cur_next        = cur_reg;
        idx_next        = idx_reg;
        chk_next        = 1'b0;
        res_ok_next     = res_ok_reg;
        res_handle_next = res_handle_reg;
        res_obj_next    = res_obj_reg;
        res_cnt_next    = res_cnt_reg;
        wr_en           = 1'b0;
        wr_addr         = rd_slot_reg;
        wr_data         = eff;
        rd_addr         = '0;
        out_valid_next  = out_valid_reg;
        if (out_valid_reg && m_tready) out_valid_next = 1'b0;
        case (state_reg)
            ctc_pkg::ST_IDLE: begin
                pop             = q_valid;
                cur_next        = q_cmd;
                idx_next        = '0;
                res_ok_next     = 1'b0;
                res_handle_next = 64'd0;
                res_obj_next    = 64'd0;
                res_cnt_next    = 5'd0;
            end
            ctc_pkg::ST_SWEEP: begin
                wr_en       = 1'b1;
                wr_addr     = idx_reg[SW-1:0];
                wr_data.typ = 3'd0;
                wr_data.rgt = 7'd0;
                wr_data.obj = 64'd0;
                wr_data.gen = ctc_pkg::seed_gen(principal, 8'(idx_reg) + 8'd1);
                idx_next    = idx_reg + 1'b1;
                res_ok_next = (principal != 64'd0);
            end
            ctc_pkg::ST_SCAN: begin
                // issue one read a cycle, judge the entry read the cycle before
                if (idx_reg < IW'(SLOTS)) begin
                    rd_addr  = idx_reg[SW-1:0];
                    idx_next = idx_reg + 1'b1;
                    chk_next = 1'b1;
                end
                if (scan_end) begin
                    res_ok_next = (cur_reg.op == ctc_pkg::OP_COUNT);
                end else if (chk_reg) begin
                    case (cur_reg.op)
                        ctc_pkg::OP_GRANT: begin
                            if (eff.typ == 3'd0) begin
                                wr_en           = 1'b1;
                                wr_data.typ     = ty[2:0];
                                wr_data.rgt     = rg[6:0];
                                wr_data.obj     = cur_reg.obj;
                                wr_data.gen     = eff.gen;
                                res_ok_next     = 1'b1;
                                res_handle_next = {ctc_pkg::TAG_VALUE, eff.gen,
                                                   5'd0, ty[2:0], rd_n};
                            end
                        end
                        ctc_pkg::OP_FIND: begin
                            if (type_hit && rights_hit) begin
                                res_ok_next     = 1'b1;
                                res_handle_next = {ctc_pkg::TAG_VALUE, eff.gen,
                                                   5'd0, eff.typ, rd_n};
                            end
                        end
                        ctc_pkg::OP_COUNT: begin
                            if (type_hit && res_cnt_reg != ctc_pkg::COUNT_MAX)
                                res_cnt_next = res_cnt_reg + 5'd1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ctc_pkg::ST_READ: begin
                rd_addr = cur_reg.slot[SW-1:0];
            end
            ctc_pkg::ST_CHECK: begin
                if (cur_reg.op == ctc_pkg::OP_RESOLVE) begin
                    if (type_hit && cur_reg.handle[15:8] == ty
                            && eff.gen == cur_reg.handle[47:16] && rights_hit) begin
                        res_ok_next  = 1'b1;
                        res_obj_next = eff.obj;
                    end
                end else begin
                    if (eff.gen == cur_reg.handle[47:16] && eff.typ != 3'd0
                            && cur_reg.handle[15:8] == {5'd0, eff.typ}) begin
                        wr_en       = 1'b1;
                        wr_data.typ = 3'd0;
                        wr_data.rgt = 7'd0;
                        wr_data.obj = 64'd0;
                        wr_data.gen = gen_inc;
                        res_ok_next = 1'b1;
                    end
                end
            end
            ctc_pkg::ST_RESP: begin
                if (out_load) out_valid_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ctc_pkg::ST_IDLE;
            idx_reg       <= '0;
            chk_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            chk_reg       <= chk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg        <= cur_next;
        res_ok_reg     <= res_ok_next;
        res_handle_reg <= res_handle_next;
        res_obj_reg    <= res_obj_next;
        res_cnt_reg    <= res_cnt_next;
        if (out_load) begin
            out_ok_reg     <= res_ok_reg;
            out_handle_reg <= res_handle_reg;
            out_obj_reg    <= res_obj_reg;
            out_cnt_reg    <= res_cnt_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ok_reg;
    assign m_tdata  = {3'd0, out_cnt_reg, out_obj_reg, out_handle_reg};

endmodule
`default_nettype wire

[sv/capability_table_checker_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Handshake              Payload
// s_        in   s_tvalid / s_tready    tuser cmd; tdata type, rights, object, handle
// m_        out  m_tvalid / m_tready    tuser ok; tdata handle, object, type count
// cfg_      in   cfg_we                 cfg_wdata principal
//
// Init writes every slot in turn; grant, find and count scan the table with one
// table read per cycle through the single read port; resolve/revoke read one slot
// and rejected commands go straight to the response.
// One command is worked at a time; a two-deep command queue keeps accepting until full.
// Reset clears control state and marks all slots unwritten (they read as reset).
// A stalled result holds in the output register while the next command runs.
module capability_table_checker_core #(
    parameter int SLOTS = ctc_pkg::SLOTS_DEFAULT
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output      logic           s_tready,
    input  wire logic [151:0]   s_tdata,   // cap_type, rights, object_in, handle_in
    input  wire logic [2:0]     s_tuser,   // cmd
    output      logic           m_tvalid,
    input  wire logic           m_tready,
    output      logic [135:0]   m_tdata,   // handle_out, object_out, type_count, pad
    output      logic           m_tuser,   // ok
    input  wire logic           cfg_we,
    input  wire logic [63:0]    cfg_wdata
);

    logic [63:0]    principal_reg;
    logic           push, q_full, q_valid, pop;
    ctc_pkg::cmd_t  push_cmd, q_cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            principal_reg <= 64'd0;
        end else if (cfg_we) begin
            principal_reg <= cfg_wdata;
        end
    end

    ctc_front #(.SLOTS(SLOTS)) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .p_zero   (principal_reg == 64'd0),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    ctc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    ctc_back #(.SLOTS(SLOTS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .principal (principal_reg),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire
